// ----- hw/rtl/u16u8_pkg.sv -----
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// Depends on nothing; used by every module of the block.
`default_nettype none

package u16u8_pkg;

  // One input item: a UTF-16 code unit and the end-of-string flag
  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_last;
  } in_data_t;

  // One result item: a UTF-8 byte with its run and string markers
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_data_t;

  // All bytes caused by one input unit, oldest in bytes[0]
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            str_last;
  } run_t;

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
  localparam logic [7:0] QMARK         = 8'h3F;
  localparam logic [7:0] LEAD2         = 8'hC0;
  localparam logic [7:0] LEAD3         = 8'hE0;
  localparam logic [7:0] LEAD4         = 8'hF0;
  localparam logic [7:0] CONT          = 8'h80;
  localparam logic [15:0] MAX1         = 16'h007F;
  localparam logic [15:0] MAX2         = 16'h07FF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

endpackage

`default_nettype wire

// ----- hw/rtl/u16u8_front.sv -----
// Front end: accepts code units, tracks the held high surrogate and
// encodes each unit into a run of 0 to 4 bytes. Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire u16u8_pkg::in_data_t  in_data,
  input  wire logic                 q_full,
  output logic                      in_full,
  output logic                      run_push,
  output u16u8_pkg::run_t           run_data
);

  logic        pend_r, pend_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        accept;
  logic        is_high, is_low, is_pair, is_hold;
  logic [15:0] unit;
  logic [20:0] cp;
  logic [3:0][7:0] e;
  logic [2:0]  ne;

  assign unit    = in_data.code_unit;
  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign is_high = (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign is_low  = (unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
  assign is_pair = pend_r && is_low;
  assign is_hold = !is_pair && is_high && !in_data.string_last;
  assign cp      = u16u8_pkg::SUPP_BASE + {1'b0, held_r, unit[9:0]};

  // Encoding of the unit on its own
  always_comb begin
    e  = '0;
    ne = 3'd0;
    if (is_hold) begin
      ne = 3'd0;
    end else if (is_low) begin
      e[0] = u16u8_pkg::QMARK;
      ne   = 3'd1;
    end else if (unit <= u16u8_pkg::MAX1) begin
      e[0] = unit[7:0];
      ne   = 3'd1;
    end else if (unit <= u16u8_pkg::MAX2) begin
      e[0] = u16u8_pkg::LEAD2 | {3'b000, unit[10:6]};
      e[1] = u16u8_pkg::CONT | {2'b00, unit[5:0]};
      ne   = 3'd2;
    end else begin
      e[0] = u16u8_pkg::LEAD3 | {4'b0000, unit[15:12]};
      e[1] = u16u8_pkg::CONT | {2'b00, unit[11:6]};
      e[2] = u16u8_pkg::CONT | {2'b00, unit[5:0]};
      ne   = 3'd3;
    end
  end

  always_comb begin
    run_data          = '0;
    run_data.str_last = in_data.string_last;
    if (is_pair) begin
      run_data.bytes[0] = u16u8_pkg::LEAD4 | {5'b00000, cp[20:18]};
      run_data.bytes[1] = u16u8_pkg::CONT | {2'b00, cp[17:12]};
      run_data.bytes[2] = u16u8_pkg::CONT | {2'b00, cp[11:6]};
      run_data.bytes[3] = u16u8_pkg::CONT | {2'b00, cp[5:0]};
      run_data.cnt      = 3'd4;
    end else if (pend_r) begin
      // broken pair: '?' for the held unit, then this unit's own bytes
      run_data.bytes[0] = u16u8_pkg::QMARK;
      run_data.bytes[1] = e[0];
      run_data.bytes[2] = e[1];
      run_data.bytes[3] = e[2];
      run_data.cnt      = ne + 3'd1;
    end else begin
      run_data.bytes = e;
      run_data.cnt   = ne;
    end
  end

  assign run_push = accept && (run_data.cnt != 3'd0);

  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (accept) begin
      pend_nxt = is_hold;
      held_nxt = is_hold ? unit[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= 10'd0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_hold |=> pend_r)
    else $error("high surrogate not held");
  a_last_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.string_last |=> !pend_r)
    else $error("surrogate held past end of string");
  a_hold_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_hold && !pend_r |-> !run_push)
    else $error("held unit produced bytes");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/u16u8_queue.sv -----
// Short queue of encoded byte runs between the front and back ends.
// Depends on u16u8_pkg for the run type.
`default_nettype none

module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u16u8_pkg::run_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output u16u8_pkg::run_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  u16u8_pkg::run_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (head.cnt != 3'd0) && (head.cnt <= 3'd4))
    else $error("queued run has bad length");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/u16u8_back.sv -----
// Back end: walks each queued run byte by byte into the output register.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire u16u8_pkg::run_t       q_head,
  output logic                       q_pop,
  input  wire logic                  out_pop,
  output logic                       out_empty,
  output u16u8_pkg::out_data_t       out_data
);

  logic                  valid_r, valid_nxt;
  logic [1:0]            idx_r, idx_nxt;
  u16u8_pkg::out_data_t  data_r, data_nxt;
  logic                  load, last_byte;

  assign load      = !q_empty && (!valid_r || out_pop);
  assign last_byte = ({1'b0, idx_r} == (q_head.cnt - 3'd1));
  assign q_pop     = load && last_byte;
  assign out_empty = !valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt            = 1'b1;
      idx_nxt              = last_byte ? 2'd0 : idx_r + 2'd1;
      data_nxt.out_byte    = q_head.bytes[idx_r];
      data_nxt.run_last    = last_byte;
      data_nxt.string_done = last_byte && q_head.str_last;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !q_empty && ({1'b0, idx_r} < q_head.cnt))
    else $error("byte index outside current run");
  a_done_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.string_done |-> data_r.run_last)
    else $error("string end not on a run end");
  a_pop_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (idx_r == 2'd0))
    else $error("byte index not rewound after run");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// UTF-16 to UTF-8 transcoder, top level.
// Input channel: in_push / in_full with in_data (code_unit, string_last);
// a unit transfers on a clock edge with in_push high and in_full low.
// Result channel: out_empty / out_pop with out_data (out_byte, run_last,
// string_done); the oldest byte shows while out_empty is low and transfers
// on an edge with out_pop high.
// Each unit gives 0 to 4 bytes: a held high surrogate gives none until its
// partner arrives, then the pair gives four. run_last marks the last byte
// of each run, string_done the last byte of the string.
// A unit's bytes pass through the run queue and then the output register.
// Throughput: one byte per cycle out while out_pop stays high, so one unit per
// cycle for ASCII; an n-byte run holds the byte serializer until its n bytes are
// out, and the run queue (QDEPTH entries) lets input continue until it fills.
// A stall on out_pop holds the output byte; the queue fills and then
// in_full rises. rst_n (synchronous, active low) empties the queue, drops
// the output byte and forgets any held surrogate.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
`default_nettype none

module utf16_to_utf8_transcoder #(
  parameter int QDEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire u16u8_pkg::in_data_t   in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output u16u8_pkg::out_data_t       out_data
);

  logic            run_push, q_full, q_empty, q_pop;
  u16u8_pkg::run_t run_data, q_head;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_full  (in_full),
    .run_push (run_push),
    .run_data (run_data)
  );

  u16u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (run_push),
    .push_data (run_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
